@@ rtl/swmm_pkg.sv @@
// Shared types and constants for the sliding-window min/max unit.
// No dependencies; imported by the top level and its checker.
package swmm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int CFG_W    = 11;

  // Register indexes on the configuration port
  localparam logic CFG_WINDOW_SIZE = 1'b0;
  localparam logic CFG_MODE        = 1'b1;

  // Mode register values
  localparam logic MODE_MIN = 1'b0;
  localparam logic MODE_MAX = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_TAIL,
    ST_PUSH,
    ST_OUT
  } state_t;

endpackage

@@ rtl/sliding_window_min_max_unit.sv @@
// Sliding-window min/max over signed 32-bit samples with a monotonic deque in RAM.
// Depends on swmm_pkg and swmm_ram.
// Each accepted sample drops expired head and dominated tail entries (one RAM read
// each) and is pushed; once the window fills, its result is loaded, waiting while the
// previous beat is held, before the next sample. A result loads as s_tready returns.
// Reset (rst, synchronous): clears control, stream state and config only.
module sliding_window_min_max_unit
  import swmm_pkg::*;
#(
  parameter int WINDOW_MAX = 1024
) (
  input  logic                clk,
  input  logic                rst,
  // config write port
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  // sample stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [SAMPLE_W-1:0] s_tdata,   // [31:0] sample
  input  logic                s_tlast,   // last_sample
  // result stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [SAMPLE_W-1:0] m_tdata,   // [31:0] extremum
  output logic                m_tlast    // last_result
);

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int RW = 2 * SAMPLE_W;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(WINDOW_MAX)) begin
      s = s - (CW+1)'(WINDOW_MAX);
    end
    return s[AW-1:0];
  endfunction

  state_t state, state_next;

  logic [CFG_W-1:0]    window_size;
  logic                mode;

  logic [SAMPLE_W-1:0] x_reg;
  logic                last_reg;
  logic [SAMPLE_W-1:0] pos_reg;
  logic [CW-1:0]       k_reg, k_sel;

  logic [AW-1:0]       head, head_next;
  logic [CW-1:0]       count, count_next, cnt_after;
  logic [SAMPLE_W-1:0] sample_pos, sample_pos_next;
  logic                filled, filled_next;
  logic                use_x, use_x_next;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [RW-1:0]       ram_rdata;
  logic [SAMPLE_W-1:0] rd_val, rd_pos;

  logic                accept, out_load, dominated;

  assign rd_val = ram_rdata[SAMPLE_W-1:0];
  assign rd_pos = ram_rdata[RW-1:SAMPLE_W];
  assign accept = s_tvalid && s_tready;

  swmm_ram #(
    .WIDTH (RW),
    .DEPTH (WINDOW_MAX)
  ) u_deque (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({pos_reg, x_reg}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (window_size == '0) begin
      k_sel = CW'(1);
    end else if (32'(window_size) > 32'(WINDOW_MAX)) begin
      k_sel = CW'(WINDOW_MAX);
    end else begin
      k_sel = CW'(window_size);
    end
  end

  always_comb begin
    if (mode == MODE_MAX) begin
      dominated = !($signed(x_reg) < $signed(rd_val));
    end else begin
      dominated = !($signed(rd_val) < $signed(x_reg));
    end
  end

  always_comb begin
    state_next      = state;
    head_next       = head;
    count_next      = count;
    sample_pos_next = sample_pos;
    filled_next     = filled;
    use_x_next      = use_x;
    cnt_after       = count;
    ram_we          = 1'b0;
    ram_waddr       = wrap_add(head, count);
    ram_raddr       = head;
    s_tready        = 1'b0;
    out_load        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          sample_pos_next = sample_pos + 32'd1;
          state_next      = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (count != '0 && (pos_reg - rd_pos) >= 32'(k_reg)) begin
          head_next  = wrap_add(head, CW'(1));
          count_next = count - CW'(1);
          ram_raddr  = head_next;
        end else if (count != '0) begin
          ram_raddr  = wrap_add(head, count - CW'(1));
          state_next = ST_TAIL;
        end else begin
          state_next = ST_PUSH;
        end
      end
      ST_TAIL: begin
        if (count != '0 && dominated) begin
          count_next = count - CW'(1);
          if (count == CW'(1)) begin
            state_next = ST_PUSH;
          end else begin
            ram_raddr = wrap_add(head, count - CW'(2));
          end
        end else begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        ram_we = 1'b1;
        if (count == CW'(WINDOW_MAX)) begin
          head_next = wrap_add(head, CW'(1));
          cnt_after = count - CW'(1);
        end
        count_next = cnt_after + CW'(1);
        use_x_next = (cnt_after == '0);
        ram_raddr  = head_next;
        if (pos_reg >= 32'(k_reg)) begin
          filled_next = 1'b1;
        end
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!filled || !m_tvalid || m_tready) begin
          out_load   = filled;
          state_next = ST_IDLE;
          if (last_reg) begin
            head_next       = '0;
            count_next      = '0;
            sample_pos_next = '0;
            filled_next     = 1'b0;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      count      <= '0;
      sample_pos <= '0;
      filled     <= 1'b0;
      use_x      <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      count      <= count_next;
      sample_pos <= sample_pos_next;
      filled     <= filled_next;
      use_x      <= use_x_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= CFG_W'(1);
      mode        <= MODE_MIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_SIZE: window_size <= cfg_data;
        CFG_MODE:        mode        <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_reg    <= s_tdata;
      last_reg <= s_tlast;
      pos_reg  <= sample_pos + 32'd1;
      k_reg    <= k_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= use_x ? x_reg : rd_val;
      m_tlast <= last_reg;
    end
  end

endmodule

@@ rtl/swmm_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module swmm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/swmm_checker.sv @@
// Port-level checker for sliding_window_min_max_unit, with its bind statement.
// Depends on swmm_pkg for the data width.
module swmm_checker
  import swmm_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [SAMPLE_W-1:0] m_tdata,
  input logic                m_tlast
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result beat changed while stalled");

  // after a sample is taken, the input stays not ready while that sample is worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
    else $error("input taken again too soon");

  // a new result appears only while the block is back at the input side
  a_new_result_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("result loaded while sample still in work");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("reset did not clear outputs");

endmodule

bind sliding_window_min_max_unit swmm_checker u_swmm_checker (.*);

@@ sim/testbench.sv @@
// Self-checking testbench for sliding_window_min_max_unit: directed table, then random streams.
// Depends on swmm_pkg and the unit's RTL; a local deque predictor supplies expected beats.
module testbench;
  import swmm_pkg::*;

  localparam int WINDOW_MAX   = 1024;
  localparam int RANDOM_BEATS = 1450;
  localparam int SETTLE_CYC   = WINDOW_MAX + 32;
  localparam int LIMIT_CYC    = 1_000_000;

  typedef enum logic { ROW_CFG, ROW_BEAT } row_kind_t;
  typedef enum logic [1:0] { CHK_MODEL, CHK_VALUE, CHK_NONE } chk_t;

  typedef struct packed {
    row_kind_t        kind;
    logic             idx;
    logic [CFG_W-1:0] cfg_val;
    logic [31:0]      smp;
    logic             lst;
    chk_t             chk;
    logic [31:0]      exp_val;
    logic             exp_last;
  } dir_row_t;

  typedef struct packed {
    logic [31:0] extremum;
    logic        last_flag;
  } result_t;

  localparam int DIR_ROWS = 34;

  dir_row_t directed_rows [DIR_ROWS] = '{
    '{ROW_BEAT, CFG_WINDOW_SIZE, 11'd0,    32'h7FFFFFFF, 1'b0, CHK_VALUE, 32'h7FFFFFFF, 1'b0},
    '{ROW_BEAT, CFG_WINDOW_SIZE, 11'd0,    32'h80000000, 1'b1, CHK_VALUE, 32'h80000000, 1'b1},
    '{ROW_CFG,  CFG_WINDOW_SIZE, 11'd3,    32'h0,        1'b0, CHK_NONE,  32'h0,        1'b0},
    '{ROW_BEAT, CFG_WINDOW_SIZE, 11'd0,    32'h00000005, 1'b0, CHK_NONE,  32'h0,        1'b0},
    '{ROW_BEAT, CFG_WINDOW_SIZE, 11'd0,    32'hFFFFFFFF, 1'b0, CHK_NONE,  32'h0,        1'b0},
    '{ROW_BEAT, CFG_WINDOW_SIZE, 11'd0,    32'h00000005, 1'b0, CHK_VALUE, 32'hFFFFFFFF, 1'b0},
    '{ROW_BEAT, CFG_WINDOW_SIZE, 11'd0,    32'h00000007, 1'b0, CHK_VALUE, 32'hFFFFFFFF, 1'b0},
    '{ROW_BEAT, CFG_WINDOW_SIZE, 11'd0,    32'h00000007, 1'b0, CHK_VALUE, 32'h00000005, 1'b0},
    '{ROW_BEAT, CFG_WINDOW_SIZE, 11'd0,    32'h00000005, 1'b1, CHK_VALUE, 32'h00000005, 1'b1},
    '{ROW_CFG,  CFG_MODE,        11'd1,    32'h0,        1'b0, CHK_NONE,  32'h0,        1'b0},
    '{ROW_BEAT, CFG_WINDOW_SIZE, 11'd0,    32'h00000003, 1'b0, CHK_NONE,  32'h0,        1'b0},
    '{ROW_BEAT, CFG_WINDOW_SIZE, 11'd0,    32'h00000003, 1'b0, CHK_NONE,  32'h0,        1'b0},
    '{ROW_BEAT, CFG_WINDOW_SIZE, 11'd0,    32'h00000003, 1'b0, CHK_VALUE, 32'h00000003, 1'b0},
    '{ROW_BEAT, CFG_WINDOW_SIZE, 11'd0,    32'h80000000, 1'b0, CHK_VALUE, 32'h00000003, 1'b0},
    '{ROW_BEAT, CFG_WINDOW_SIZE, 11'd0,    32'h80000000, 1'b0, CHK_VALUE, 32'h00000003, 1'b0},
    '{ROW_BEAT, CFG_WINDOW_SIZE, 11'd0,    32'h80000000, 1'b0, CHK_VALUE, 32'h80000000, 1'b0},
    '{ROW_CFG,  CFG_WINDOW_SIZE, 11'd0,    32'h0,        1'b0, CHK_NONE,  32'h0,        1'b0},
    '{ROW_BEAT, CFG_WINDOW_SIZE, 11'd0,    32'h7FFFFFFF, 1'b0, CHK_VALUE, 32'h7FFFFFFF, 1'b0},
    '{ROW_BEAT, CFG_WINDOW_SIZE, 11'd0,    32'hFFFFFFFB, 1'b1, CHK_VALUE, 32'hFFFFFFFB, 1'b1},
    '{ROW_CFG,  CFG_WINDOW_SIZE, 11'd2047, 32'h0,        1'b0, CHK_NONE,  32'h0,        1'b0},
    '{ROW_BEAT, CFG_WINDOW_SIZE, 11'd0,    32'h00000001, 1'b0, CHK_NONE,  32'h0,        1'b0},
    '{ROW_BEAT, CFG_WINDOW_SIZE, 11'd0,    32'h00000002, 1'b1, CHK_NONE,  32'h0,        1'b0},
    '{ROW_CFG,  CFG_WINDOW_SIZE, 11'd2,    32'h0,        1'b0, CHK_NONE,  32'h0,        1'b0},
    '{ROW_CFG,  CFG_MODE,        11'd0,    32'h0,        1'b0, CHK_NONE,  32'h0,        1'b0},
    '{ROW_BEAT, CFG_WINDOW_SIZE, 11'd0,    32'h00000009, 1'b0, CHK_NONE,  32'h0,        1'b0},
    '{ROW_BEAT, CFG_WINDOW_SIZE, 11'd0,    32'h00000004, 1'b0, CHK_VALUE, 32'h00000004, 1'b0},
    '{ROW_CFG,  CFG_WINDOW_SIZE, 11'd2047, 32'h0,        1'b0, CHK_NONE,  32'h0,        1'b0},
    '{ROW_BEAT, CFG_WINDOW_SIZE, 11'd0,    32'h00000006, 1'b0, CHK_VALUE, 32'h00000004, 1'b0},
    '{ROW_CFG,  CFG_MODE,        11'd1,    32'h0,        1'b0, CHK_NONE,  32'h0,        1'b0},
    '{ROW_BEAT, CFG_WINDOW_SIZE, 11'd0,    32'h00000001, 1'b0, CHK_MODEL, 32'h0,        1'b0},
    '{ROW_BEAT, CFG_WINDOW_SIZE, 11'd0,    32'h00000064, 1'b1, CHK_MODEL, 32'h0,        1'b0},
    '{ROW_CFG,  CFG_WINDOW_SIZE, 11'd1024, 32'h0,        1'b0, CHK_NONE,  32'h0,        1'b0},
    '{ROW_BEAT, CFG_WINDOW_SIZE, 11'd0,    32'h00000000, 1'b0, CHK_NONE,  32'h0,        1'b0},
    '{ROW_BEAT, CFG_WINDOW_SIZE, 11'd0,    32'hFFFFFFFF, 1'b1, CHK_NONE,  32'h0,        1'b0}
  };

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic                cfg_index;
  logic [CFG_W-1:0]    cfg_data;
  logic                s_tvalid;
  logic                s_tready;
  logic [SAMPLE_W-1:0] s_tdata;   // [31:0] sample
  logic                s_tlast;   // last_sample
  logic                m_tvalid;
  logic                m_tready;
  logic [SAMPLE_W-1:0] m_tdata;   // [31:0] extremum
  logic                m_tlast;   // last_result

  // predictor state
  logic [31:0]      dq_val [WINDOW_MAX];
  logic [31:0]      dq_pos [WINDOW_MAX];
  int unsigned      dq_head;
  int unsigned      dq_count;
  logic [31:0]      pos_ctr;
  bit               win_filled;
  logic [CFG_W-1:0] win_reg;
  logic             mode_reg;

  result_t     expected_results [$];
  int          mismatch_count;
  int          beats_sent;
  int          burst_left;
  logic [31:0] trend_val;

  sliding_window_min_max_unit #(.WINDOW_MAX(WINDOW_MAX)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_CYC * 10);
    $display("FAIL");
    $finish;
  end

  function automatic int unsigned eff_window(input logic [CFG_W-1:0] w);
    if (w == 0) return 1;
    if (w > WINDOW_MAX) return WINDOW_MAX;
    return 32'(w);
  endfunction

  function automatic void clear_window();
    dq_head    = 0;
    dq_count   = 0;
    pos_ctr    = '0;
    win_filled = 1'b0;
  endfunction

  function automatic void step_window(input logic [31:0] x, input logic lst,
                                      output bit has, output logic [31:0] ext);
    int unsigned k;
    int unsigned tail;
    logic [31:0] age;
    bit          scan;
    k = eff_window(win_reg);
    pos_ctr = pos_ctr + 32'd1;
    scan = 1'b1;
    while (scan && dq_count > 0) begin
      age = pos_ctr - dq_pos[dq_head];
      if (age >= k) begin
        dq_head = (dq_head + 1) % WINDOW_MAX;
        dq_count--;
      end else begin
        scan = 1'b0;
      end
    end
    scan = 1'b1;
    while (scan && dq_count > 0) begin
      tail = (dq_head + dq_count - 1) % WINDOW_MAX;
      if (mode_reg == MODE_MAX)
        scan = $signed(x) >= $signed(dq_val[tail]);
      else
        scan = $signed(x) <= $signed(dq_val[tail]);
      if (scan) dq_count--;
    end
    if (dq_count >= WINDOW_MAX) begin
      dq_head = (dq_head + 1) % WINDOW_MAX;
      dq_count--;
    end
    tail = (dq_head + dq_count) % WINDOW_MAX;
    dq_val[tail] = x;
    dq_pos[tail] = pos_ctr;
    dq_count++;
    if (pos_ctr >= k) win_filled = 1'b1;
    has = win_filled;
    ext = dq_val[dq_head];
    if (lst) clear_window();
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < 50) $display("ERROR @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  // wait out all results plus the longest deque walk before touching config
  task automatic settle();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == CFG_WINDOW_SIZE) win_reg = val;
    else mode_reg = val[0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_sample(input logic [31:0] smp, input logic lst, input chk_t chk,
                             input logic [31:0] ev, input logic el);
    int          gap;
    bit          has;
    logic [31:0] ext;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
    step_window(smp, lst, has, ext);
    case (chk)
      CHK_MODEL: begin
        if (has) expected_results.push_back('{extremum: ext, last_flag: lst});
      end
      CHK_VALUE: begin
        expected_results.push_back('{extremum: ev, last_flag: el});
      end
      default: begin
      end
    endcase
  endtask

  function automatic logic [31:0] next_sample(input int style);
    case (style)
      0: return $urandom;
      1: return $urandom_range(0, 6) - 3;
      2: begin
        trend_val = trend_val + $urandom_range(0, 3);
        return trend_val;
      end
      3: begin
        trend_val = trend_val - $urandom_range(0, 3);
        return trend_val;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h80000000;
          1: return 32'h7FFFFFFF;
          2: return 32'h00000000;
          3: return 32'hFFFFFFFF;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // result side: stall pattern and checker
  initial begin : rx_side
    int rx_mode;
    int phase_left;
    m_tready   <= 1'b0;
    phase_left = 0;
    rx_mode    = 0;
    forever begin
      @(posedge clk);
      if (phase_left == 0) begin
        rx_mode    = $urandom_range(0, 3);
        phase_left = $urandom_range(16, 200);
      end
      phase_left--;
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= ((phase_left % 32) < 6);
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected beat extremum=%h last=%b", m_tdata, m_tlast));
      end else begin
        want = expected_results.pop_front();
        if (m_tdata !== want.extremum)
          report_mismatch($sformatf("extremum %h, want %h", m_tdata, want.extremum));
        if (m_tlast !== want.last_flag)
          report_mismatch($sformatf("last %b, want %b", m_tlast, want.last_flag));
      end
    end
  end

  initial begin : stimulus
    int          r;
    int          kk;
    int          n_streams;
    int          len;
    int          style;
    bit          close_it;
    logic [CFG_W-1:0] w;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_WINDOW_SIZE;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    mismatch_count = 0;
    beats_sent     = 0;
    burst_left     = 0;
    trend_val      = '0;
    clear_window();
    win_reg  = 11'd1;
    mode_reg = MODE_MIN;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle();
        write_cfg(directed_rows[i].idx, directed_rows[i].cfg_val);
      end else begin
        push_sample(directed_rows[i].smp, directed_rows[i].lst, directed_rows[i].chk,
                    directed_rows[i].exp_val, directed_rows[i].exp_last);
      end
    end

    while (beats_sent < DIR_ROWS + RANDOM_BEATS) begin
      settle();
      if ($urandom_range(0, 9) < 7) begin
        r = $urandom_range(0, 99);
        if (r < 60)      w = CFG_W'($urandom_range(1, 8));
        else if (r < 85) w = CFG_W'($urandom_range(9, 40));
        else if (r < 90) w = 11'd0;
        else if (r < 95) w = ($urandom_range(0, 1) == 0) ? 11'd1024 : 11'd2047;
        else             w = CFG_W'($urandom_range(41, 2047));
        write_cfg(CFG_WINDOW_SIZE, w);
      end
      if ($urandom_range(0, 1) == 0)
        write_cfg(CFG_MODE, CFG_W'(($urandom_range(0, 1) == 0) ? MODE_MIN : MODE_MAX));
      kk = eff_window(win_reg);
      if (kk > 40) kk = 40;
      n_streams = $urandom_range(1, 3);
      for (int s = 0; s < n_streams; s++) begin
        len       = $urandom_range(1, 3 * kk + 8);
        style     = $urandom_range(0, 4);
        trend_val = $urandom;
        close_it  = (s != n_streams - 1) || ($urandom_range(0, 3) != 0);
        for (int j = 0; j < len; j++)
          push_sample(next_sample(style), close_it && (j == len - 1), CHK_MODEL, '0, 1'b0);
      end
    end

    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
